### rtl/ipcp_pkg.sv
// Shared types and constants for the inverse Park/Clarke sine-PWM pipeline.
package ipcp_pkg;

  // Config register indexes
  typedef enum logic [0:0] {
    REG_SUPPLY_VOLTAGE = 1'b0,
    REG_PWM_PERIOD     = 1'b1
  } reg_index_t;

  localparam logic [15:0] VS_RESET     = 16'd3072;
  localparam logic [15:0] PERIOD_RESET = 16'd1000;

  // Phase word offset from sine to cosine
  localparam logic [15:0] QUARTER_TURN = 16'h4000;

  // sqrt(3) in unsigned Q16
  localparam int          SQRT3_FRAC = 16;
  localparam logic [16:0] SQRT3_Q16  = 17'd113512;

  // Quarter-wave sine polynomial, Q30, highest order first
  localparam int          NHORNER = 5;
  localparam logic [30:0] C11     = 31'd3864;
  localparam logic [30:0] HORNER_COEF [NHORNER] = '{
    31'd172272, 31'd5026995, 31'd85569306, 31'd693598668, 31'd1686629773
  };

  // Scaled-quotient width and divider depth
  localparam int XW        = 33;
  localparam int DIV_STEPS = 16;
  localparam int NLANE     = 3;

  typedef struct packed {
    logic [30:0] p;    // Horner partial, Q30
    logic [30:0] z2;   // z^2, Q30
    logic [14:0] r;    // folded quadrant phase
    logic        neg;  // lower half-turn sign
  } trig_lane_t;

  typedef struct packed {
    trig_lane_t         sn;
    trig_lane_t         cs;
    logic signed [15:0] uq;
  } horner_t;

  typedef struct packed {
    logic [XW-1:0]        rem;
    logic [DIV_STEPS-1:0] quo;
    logic                 over;  // saturated (or nonzero when negative)
    logic                 neg;
  } div_lane_t;

  typedef div_lane_t [NLANE-1:0] div_row_t;

endpackage

### rtl/ipcp_horner_cell.sv
// One Horner step of the sine polynomial, for the sine and cosine lanes.
module ipcp_horner_cell #(
  parameter logic [30:0] COEF = 31'd1
) (
  input  logic               clk,
  input  logic               en,
  input  ipcp_pkg::horner_t  d_in,
  output ipcp_pkg::horner_t  d_out
);

  logic [61:0]       prod_s;
  logic [61:0]       prod_c;
  ipcp_pkg::horner_t d_out_next;

  assign prod_s = d_in.sn.p * d_in.sn.z2;
  assign prod_c = d_in.cs.p * d_in.cs.z2;

  // p never exceeds COEF, so the subtraction cannot wrap
  always_comb begin
    d_out_next      = d_in;
    d_out_next.sn.p = COEF - prod_s[60:30];
    d_out_next.cs.p = COEF - prod_c[60:30];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= d_out_next;
    end
  end

endmodule

### rtl/ipcp_div_cell.sv
// One restoring-division step (one quotient bit) for all three phase lanes.
module ipcp_div_cell #(
  parameter int BIT = 0
) (
  input  logic               clk,
  input  logic               en,
  input  logic [15:0]        divisor,
  input  ipcp_pkg::div_row_t d_in,
  output ipcp_pkg::div_row_t d_out
);

  localparam int XW = ipcp_pkg::XW;

  logic [XW-1:0]      shifted;
  ipcp_pkg::div_row_t d_out_next;

  assign shifted = XW'(divisor) << BIT;

  always_comb begin
    d_out_next = d_in;
    for (int l = 0; l < ipcp_pkg::NLANE; l++) begin
      if (d_in[l].rem >= shifted) begin
        d_out_next[l].rem      = d_in[l].rem - shifted;
        d_out_next[l].quo[BIT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= d_out_next;
    end
  end

endmodule

### rtl/inverse_park_clarke_pwm.sv
// Inverse Park / inverse Clarke sine-PWM stage: angle and uq in, three compare values out.
//
// Input stream s_axis carries one request per beat: electrical angle (65536 = one
// turn) and a signed q-axis voltage in 1/256 V. Output stream m_axis returns the
// three phase compare values, each saturated to 0..pwm_period, plus a clip flag.
// Supply voltage and PWM period are set through cfg_wr_en/cfg_index/cfg_data; the user
// must set them only while no request is in flight, as the block does not enforce this.
// They take effect on the next request. A request passes through the row of cells: input
// fold, five Horner cells, eight arithmetic stages, divider entry and sixteen divider cells
// (one quotient bit each), then shows up on m_axis_tvalid.
// Throughput: one request per clock while the output buffer has room.
// When the receiver stalls, a two-entry output buffer keeps taking results; once
// both entries are full the whole row of cells holds and s_axis_tready drops.
// Synchronous reset empties the pipeline and the output buffer and loads the
// supply voltage with 3072 (12 V) and the period with 1000.
// Zero supply voltage gives all-zero compare values with the clip flag set.
module inverse_park_clarke_pwm #(
  parameter int TRIG_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // angle_phase[15:0], uq[31:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // duty_a[15:0], duty_b[31:16], duty_c[47:32], clipped[48]
  input  logic        cfg_wr_en,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int F    = TRIG_FRAC_BITS;
  localparam int SW   = F + 2;        // signed sin/cos
  localparam int AW   = F + 18;       // alpha, beta
  localparam int PW   = AW + 18;      // beta * sqrt3
  localparam int DW   = F + 35;       // doubled phase voltage
  localparam int MW   = DW - 1;       // its magnitude
  localparam int LW   = MW / 2;
  localparam int UW   = MW - LW;
  localparam int K    = F + 17;
  localparam int SH   = 30 - F;
  localparam logic [31:0] RND_ADD = 32'd1 << (29 - F);
  localparam int XW   = ipcp_pkg::XW;
  localparam int NH   = ipcp_pkg::NHORNER;
  localparam int ND   = ipcp_pkg::DIV_STEPS;
  localparam int NL   = ipcp_pkg::NLANE;
  localparam int NST  = 1 + NH + 8 + 1 + ND;

  // config
  logic [15:0]   supply_voltage;
  logic [15:0]   pwm_period;
  logic [XW-1:0] lim;
  logic          vs_zero;

  // flow control
  logic [NST-1:0] vld;
  logic           adv;
  logic           push;
  logic           out_v;
  logic           sk_v;
  logic [55:0]    out_d;
  logic [55:0]    sk_d;
  logic [55:0]    res;

  // datapath
  logic [15:0]             ph_s;
  logic [15:0]             ph_c;
  logic [14:0]             r_s;
  logic [14:0]             r_c;
  logic [29:0]             rr_s;
  logic [29:0]             rr_c;
  ipcp_pkg::horner_t       h [NH+1];
  logic [45:0]             tp_s;
  logic [45:0]             tp_c;
  logic [30:0]             t1_s;
  logic [30:0]             t1_c;
  logic                    t1_neg_s;
  logic                    t1_neg_c;
  logic signed [15:0]      t1_uq;
  logic [31:0]             rs_s;
  logic [31:0]             rs_c;
  logic [31:0]             ms_s;
  logic [31:0]             ms_c;
  logic signed [SW-1:0]    t2_sn;
  logic signed [SW-1:0]    t2_cs;
  logic signed [15:0]      t2_uq;
  logic signed [AW-1:0]    pa;
  logic signed [AW-1:0]    pb;
  logic signed [AW-1:0]    m1_alpha;
  logic signed [AW-1:0]    m1_beta;
  logic signed [PW-1:0]    s3_prod;
  logic signed [AW-1:0]    m2_alpha;
  logic signed [DW-1:0]    m2_s3b;
  logic signed [DW-1:0]    a16;
  logic signed [DW-1:0]    vfull;
  logic signed [DW-1:0]    m3_d [NL];
  logic                    m4_neg [NL];
  logic [MW-1:0]           m4_mag [NL];
  logic                    m5_neg [NL];
  logic [LW+15:0]          m5_lo [NL];
  logic [UW+15:0]          m5_hi [NL];
  logic [MW+15:0]          sum_w [NL];
  logic                    m6_neg [NL];
  logic [XW-1:0]           m6_x [NL];
  ipcp_pkg::div_row_t      dr [ND+1];
  logic [15:0]             duty [NL];
  logic                    clip;

  function automatic logic [14:0] fold_phase(input logic [15:0] ph);
    return ph[14] ? (15'(ipcp_pkg::QUARTER_TURN) - {1'b0, ph[13:0]}) : {1'b0, ph[13:0]};
  endfunction

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      supply_voltage <= ipcp_pkg::VS_RESET;
      pwm_period     <= ipcp_pkg::PERIOD_RESET;
    end else if (cfg_wr_en) begin
      unique case (ipcp_pkg::reg_index_t'(cfg_index))
        ipcp_pkg::REG_SUPPLY_VOLTAGE: supply_voltage <= cfg_data;
        ipcp_pkg::REG_PWM_PERIOD:     pwm_period     <= cfg_data;
      endcase
    end
  end

  // saturation threshold: floor(x/vs) > period  <=>  x >= (period+1)*vs
  always_ff @(posedge clk) begin
    lim <= (XW'(pwm_period) + XW'(1)) * XW'(supply_voltage);
  end

  assign vs_zero = (supply_voltage == 16'd0);

  // ---------------- flow control ----------------
  assign adv           = !(out_v && sk_v);
  assign push          = adv && vld[NST-1];
  assign s_axis_tready = adv;
  assign m_axis_tvalid = out_v;
  assign m_axis_tdata  = out_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
      sk_v  <= 1'b0;
    end else if (!out_v || m_axis_tready) begin
      if (sk_v) begin
        out_v <= 1'b1;
        sk_v  <= 1'b0;
      end else begin
        out_v <= push;
      end
    end else if (push) begin
      sk_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v || m_axis_tready) begin
      out_d <= sk_v ? sk_d : res;
    end
    if (push) begin
      sk_d <= res;
    end
  end

  // ---------------- input fold and z^2 ----------------
  assign ph_s = s_axis_tdata[15:0];
  assign ph_c = s_axis_tdata[15:0] + ipcp_pkg::QUARTER_TURN;
  assign r_s  = fold_phase(ph_s);
  assign r_c  = fold_phase(ph_c);
  assign rr_s = r_s * r_s;
  assign rr_c = r_c * r_c;

  // z = r << 16 in Q30, so z^2 >> 30 is r^2 << 2
  always_ff @(posedge clk) begin
    if (adv) begin
      h[0].sn.p   <= ipcp_pkg::C11;
      h[0].sn.z2  <= {rr_s[28:0], 2'b00};
      h[0].sn.r   <= r_s;
      h[0].sn.neg <= ph_s[15];
      h[0].cs.p   <= ipcp_pkg::C11;
      h[0].cs.z2  <= {rr_c[28:0], 2'b00};
      h[0].cs.r   <= r_c;
      h[0].cs.neg <= ph_c[15];
      h[0].uq     <= $signed(s_axis_tdata[31:16]);
    end
  end

  // ---------------- Horner cells ----------------
  for (genvar g = 0; g < NH; g++) begin : g_horner
    ipcp_horner_cell #(
      .COEF (ipcp_pkg::HORNER_COEF[g])
    ) u_cell (
      .clk   (clk),
      .en    (adv),
      .d_in  (h[g]),
      .d_out (h[g+1])
    );
  end

  // ---------------- sin/cos finish ----------------
  // (p * z) >> 30 with z = r << 16
  assign tp_s = h[NH].sn.p * h[NH].sn.r;
  assign tp_c = h[NH].cs.p * h[NH].cs.r;

  always_ff @(posedge clk) begin
    if (adv) begin
      t1_s     <= tp_s[44:14];
      t1_c     <= tp_c[44:14];
      t1_neg_s <= h[NH].sn.neg;
      t1_neg_c <= h[NH].cs.neg;
      t1_uq    <= h[NH].uq;
    end
  end

  // round half up to F fraction bits
  assign rs_s = {1'b0, t1_s} + RND_ADD;
  assign rs_c = {1'b0, t1_c} + RND_ADD;
  assign ms_s = rs_s >> SH;
  assign ms_c = rs_c >> SH;

  always_ff @(posedge clk) begin
    if (adv) begin
      t2_sn <= t1_neg_s ? -$signed({1'b0, ms_s[F:0]}) : $signed({1'b0, ms_s[F:0]});
      t2_cs <= t1_neg_c ? -$signed({1'b0, ms_c[F:0]}) : $signed({1'b0, ms_c[F:0]});
      t2_uq <= t1_uq;
    end
  end

  // ---------------- inverse Park ----------------
  assign pa = t2_uq * t2_sn;
  assign pb = t2_uq * t2_cs;

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_alpha <= -pa;
      m1_beta  <= pb;
    end
  end

  assign s3_prod = m1_beta * $signed({1'b0, ipcp_pkg::SQRT3_Q16});

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_alpha <= m1_alpha;
      m2_s3b   <= $signed(s3_prod[DW-1:0]);
    end
  end

  // ---------------- inverse Clarke, doubled, with mid-supply offset ----------------
  assign a16   = DW'(m2_alpha) <<< ipcp_pkg::SQRT3_FRAC;
  assign vfull = $signed(DW'(supply_voltage) << (F + 16));

  always_ff @(posedge clk) begin
    if (adv) begin
      m3_d[0] <= (a16 <<< 1) + vfull;
      m3_d[1] <= vfull - a16 + m2_s3b;
      m3_d[2] <= vfull - a16 - m2_s3b;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < NL; l++) begin
        m4_neg[l] <= m3_d[l][DW-1];
        m4_mag[l] <= m3_d[l][DW-1] ? MW'(-m3_d[l]) : MW'(m3_d[l]);
      end
    end
  end

  // ---------------- scale by period: split product ----------------
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < NL; l++) begin
        m5_neg[l] <= m4_neg[l];
        m5_lo[l]  <= m4_mag[l][LW-1:0] * pwm_period;
        m5_hi[l]  <= m4_mag[l][MW-1:LW] * pwm_period;
      end
    end
  end

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      sum_w[l] = {m5_hi[l], {LW{1'b0}}} + (MW+16)'(m5_lo[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < NL; l++) begin
        m6_neg[l] <= m5_neg[l];
        m6_x[l]   <= sum_w[l][K +: XW];
      end
    end
  end

  // ---------------- divider entry ----------------
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < NL; l++) begin
        dr[0][l].rem  <= m6_x[l];
        dr[0][l].quo  <= '0;
        dr[0][l].neg  <= m6_neg[l];
        dr[0][l].over <= m6_neg[l] ? (m6_x[l] >= XW'(supply_voltage)) : (m6_x[l] >= lim);
      end
    end
  end

  // ---------------- divider cells, MSB first ----------------
  for (genvar g = 0; g < ND; g++) begin : g_div
    ipcp_div_cell #(
      .BIT (ND - 1 - g)
    ) u_cell (
      .clk     (clk),
      .en      (adv),
      .divisor (supply_voltage),
      .d_in    (dr[g]),
      .d_out   (dr[g+1])
    );
  end

  // ---------------- result select ----------------
  always_comb begin
    clip = vs_zero;
    for (int l = 0; l < NL; l++) begin
      if (vs_zero || dr[ND][l].neg) begin
        duty[l] = 16'd0;
      end else if (dr[ND][l].over) begin
        duty[l] = pwm_period;
      end else begin
        duty[l] = dr[ND][l].quo;
      end
      clip = clip | dr[ND][l].over;
    end
  end

  assign res = {7'd0, clip, duty[2], duty[1], duty[0]};

`ifndef NO_ASSERTIONS
  logic [5:0] in_flight;

  assign in_flight = 6'($countones(vld)) + 6'(out_v) + 6'(sk_v);

  a_reset_clears: assert property (@(posedge clk)
    rst |=> (vld == '0 && !out_v && !sk_v))
    else $error("pipeline not empty after reset");

  a_skid_order: assert property (@(posedge clk) disable iff (rst)
    sk_v |-> out_v)
    else $error("skid entry held while output register empty");

  a_skid_refill: assert property (@(posedge clk) disable iff (rst)
    (sk_v && m_axis_tready) |=> m_axis_tvalid)
    else $error("skid entry not moved to output");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && !(m_axis_tvalid && m_axis_tready))
      |=> in_flight == $past(in_flight) + 6'd1)
    else $error("request lost or duplicated on entry");

  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (!(s_axis_tvalid && s_axis_tready) && m_axis_tvalid && m_axis_tready)
      |=> in_flight == $past(in_flight) - 6'd1)
    else $error("request lost or duplicated on exit");
`endif

endmodule

### sim/tb_inverse_park_clarke_pwm.sv
// Testbench for inverse_park_clarke_pwm: bit-exact duty prediction, random stalls, config sweeps.
module tb_inverse_park_clarke_pwm;

  localparam int WATCHDOG_LIMIT    = 5000;
  localparam int DRAIN_PAUSE       = 40;   // pipeline is 31 deep
  localparam int RX_HOLD_CYCLES    = 400;
  localparam int RAND_SETTINGS     = 8;
  localparam int ITEMS_PER_SETTING = 70;
  localparam longint SQRT3_FIX     = 113512;  // sqrt(3), unsigned Q16

  typedef struct packed {
    logic [15:0] duty_a;
    logic [15:0] duty_b;
    logic [15:0] duty_c;
    logic        clipped;
  } duty_set_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // angle_phase[15:0], uq[31:16]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;   // duty_a[15:0], duty_b[31:16], duty_c[47:32], clipped[48]
  logic        cfg_wr_en;
  logic [0:0]  cfg_index;
  logic [15:0] cfg_data;

  // predictor copy of the config registers
  logic [15:0] vs_cfg     = 16'd3072;
  logic [15:0] period_cfg = 16'd1000;

  duty_set_t expected_duties[$];
  int error_count = 0;
  int idle_cycles = 0;
  int rx_hold_len = 0;
  bit tx_gaps     = 1'b0;
  bit rx_gaps     = 1'b0;

  inverse_park_clarke_pwm #(
    .TRIG_FRAC_BITS(16)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- prediction

  // quarter-wave sine, Horner in Q30 with truncating shifts
  function automatic longint unsigned quarter_wave_q30(input longint unsigned r);
    longint unsigned z, z2, p;
    z  = r << 16;
    z2 = (z * z) >> 30;
    p  = 64'd3864;
    p  = 64'd172272 - ((p * z2) >> 30);
    p  = 64'd5026995 - ((p * z2) >> 30);
    p  = 64'd85569306 - ((p * z2) >> 30);
    p  = 64'd693598668 - ((p * z2) >> 30);
    p  = 64'd1686629773 - ((p * z2) >> 30);
    return (p * z) >> 30;
  endfunction

  function automatic longint sine_q16(input logic [15:0] phase);
    longint unsigned r, mag;
    r = phase[13:0];
    if (phase[14]) r = 64'd16384 - r;
    mag = (quarter_wave_q30(r) + 64'd8192) >> 14;
    return phase[15] ? -longint'(mag) : longint'(mag);
  endfunction

  // floor(mag * period / (vs * 2^33)) without overflow
  function automatic longint unsigned scaled_quotient(input longint unsigned mag,
                                                      input longint unsigned vs,
                                                      input longint unsigned period);
    longint unsigned hi, lo;
    hi = mag >> 33;
    lo = mag & ((64'd1 << 33) - 64'd1);
    return (hi * period + ((lo * period) >> 33)) / vs;
  endfunction

  // returns {clip, duty}
  function automatic logic [16:0] phase_duty(input longint d, input logic [15:0] vs,
                                             input logic [15:0] period);
    longint unsigned q;
    if (d < 0) begin
      q = scaled_quotient(-d, vs, period);
      return {q != 0, 16'd0};
    end
    q = scaled_quotient(d, vs, period);
    if (q > period) return {1'b1, period};
    return {1'b0, q[15:0]};
  endfunction

  function automatic duty_set_t predict_duties(input logic [15:0] angle,
                                               input logic signed [15:0] uq);
    longint u, sn, cs, a16, s3b, vfull;
    logic [15:0] cos_phase;
    logic [16:0] ra, rb, rc;
    duty_set_t res;
    res = '0;
    if (vs_cfg == 16'd0) begin
      res.clipped = 1'b1;
      return res;
    end
    u         = uq;
    sn        = sine_q16(angle);
    cos_phase = angle + ipcp_pkg::QUARTER_TURN;
    cs        = sine_q16(cos_phase);
    a16       = -(u * sn) * 65536;
    s3b       = u * cs * SQRT3_FIX;
    vfull     = longint'(vs_cfg) << 32;
    ra = phase_duty(2 * a16 + vfull, vs_cfg, period_cfg);
    rb = phase_duty(-a16 + s3b + vfull, vs_cfg, period_cfg);
    rc = phase_duty(-a16 - s3b + vfull, vs_cfg, period_cfg);
    res.duty_a  = ra[15:0];
    res.duty_b  = rb[15:0];
    res.duty_c  = rc[15:0];
    res.clipped = ra[16] | rb[16] | rc[16];
    return res;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // three in four near the clip boundary for the current supply, rest full range
  function automatic logic [15:0] random_uq();
    int lim;
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    lim = (vs_cfg * 5) / 8 + 1;
    if (lim > 32767) lim = 32767;
    return 16'($urandom_range(0, 2 * lim) - lim);
  endfunction

  task automatic send_request(input logic [15:0] angle, input logic signed [15:0] uq);
    int gap;
    gap = tx_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {uq, angle};
    do @(posedge clk); while (!s_axis_tready);
    expected_duties.push_back(predict_duties(angle, uq));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_duties.size() != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  task automatic write_reg(input ipcp_pkg::reg_index_t idx, input logic [15:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    if (idx == ipcp_pkg::REG_SUPPLY_VOLTAGE) vs_cfg = value;
    else period_cfg = value;
  endtask

  task automatic apply_setting(input logic [15:0] vs, input logic [15:0] period);
    wait_drained();
    write_reg(ipcp_pkg::REG_SUPPLY_VOLTAGE, vs);
    write_reg(ipcp_pkg::REG_PWM_PERIOD, period);
  endtask

  // ---------------------------------------------------------------- tests

  // reset config (12 V, period 1000): quadrant edges, field extremes, clipping both ways
  task automatic test_directed_corners();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    send_request(16'h0000, 16'sd0);
    send_request(16'hFFFF, 16'sd32767);
    send_request(16'h4000, -16'sd32768);
    send_request(16'h8000, 16'sd1536);
    send_request(16'hC000, -16'sd1536);
    send_request(16'h2000, 16'sd1536);
    send_request(16'h5555, 16'sd2000);
    send_request(16'hAAAA, -16'sd2000);
    send_request(16'h0001, 16'sd1);
    send_request(16'h7FFF, -16'sd1);
    send_request(16'h1555, 16'sd32767);
    send_request(16'h3FFF, -16'sd32768);
  endtask

  // zero supply, zero period, and the smallest supply with the widest period
  task automatic test_degenerate_settings();
    apply_setting(16'd0, 16'd1000);
    send_request(16'h0000, 16'sd0);
    send_request(16'h9000, 16'sd1000);
    send_request(16'hFFFF, -16'sd32768);
    apply_setting(16'd3072, 16'd0);
    send_request(16'h0000, 16'sd0);
    send_request(16'h4000, 16'sd32767);
    send_request(16'hC000, 16'sd800);
    apply_setting(16'd1, 16'd65535);
    send_request(16'h0000, 16'sd0);
    send_request(16'h6000, -16'sd1);
  endtask

  // receiver holds off long enough to fill the pipe and the output buffer
  task automatic test_backpressure();
    apply_setting(16'd3072, 16'd1000);
    tx_gaps     = 1'b0;
    rx_gaps     = 1'b0;
    rx_hold_len = RX_HOLD_CYCLES;
    repeat (70) send_request(16'($urandom), random_uq());
    wait_drained();
  endtask

  task automatic test_random_settings();
    for (int s = 0; s < RAND_SETTINGS; s++) begin
      case (s)
        0: apply_setting(16'd3072, 16'd1000);
        1: apply_setting(16'd65535, 16'd65535);
        2: apply_setting(16'd1, 16'd1);
        3: apply_setting(16'd1, 16'd65535);
        4: apply_setting(16'd65535, 16'd1);
        5: apply_setting(16'($urandom_range(256, 8192)), 16'($urandom_range(100, 4000)));
        6: apply_setting(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
        default: apply_setting(16'd3072, 16'd1000);
      endcase
      for (int i = 0; i < ITEMS_PER_SETTING; i++) begin
        if (i % 35 == 0) begin
          tx_gaps = $urandom_range(0, 3) != 0;
          rx_gaps = $urandom_range(0, 3) != 0;
        end
        send_request(16'($urandom), random_uq());
      end
    end
  endtask

  // ---------------------------------------------------------------- processes

  initial begin
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_wr_en     <= 1'b0;
    cfg_index     <= ipcp_pkg::REG_SUPPLY_VOLTAGE;
    cfg_data      <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed_corners();
    test_degenerate_settings();
    test_backpressure();
    test_random_settings();
    wait_drained();
    if (error_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  // result side ready: random stalls, or one long hold when asked
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_len > 0) begin
        m_axis_tready <= 1'b0;
        repeat (rx_hold_len) @(posedge clk);
        rx_hold_len = 0;
        m_axis_tready <= 1'b1;
      end else if (rx_gaps && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat (1 + pick_gap()) @(posedge clk);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : check_results
    duty_set_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_duties.size() == 0) begin
        $error("result with no request outstanding: %h", m_axis_tdata);
        error_count++;
      end else begin
        want = expected_duties.pop_front();
        check_field("duty_a", want.duty_a, m_axis_tdata[15:0]);
        check_field("duty_b", want.duty_b, m_axis_tdata[31:16]);
        check_field("duty_c", want.duty_c, m_axis_tdata[47:32]);
        check_field("clipped", {15'd0, want.clipped}, {15'd0, m_axis_tdata[48]});
      end
    end
  end

  // ends a hung run: no request moving on either side for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
